// ===== hdl/md5_pkg.sv =====
// shared types, constants and step tables for the md5 digest engine
package md5_pkg;

  localparam int unsigned MD5_WORD_W      = 32;
  localparam int unsigned MD5_BLOCK_WORDS = 16;
  localparam int unsigned MD5_STEPS       = 64;

  // chaining value after reset
  localparam logic [31:0] MD5_IV_A = 32'h67452301;
  localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
  localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
  localparam logic [31:0] MD5_IV_D = 32'h10325476;

  // sequencer commands to the compression datapath
  typedef struct packed {
    logic init;     // load working registers from the chaining value
    logic step;     // run one compression step
    logic fold;     // add working registers into the chaining value
    logic restart;  // with fold: return the chaining value to its initial value
  } md5_ctrl_t;

  // per-step additive constant
  function automatic logic [31:0] md5_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // left rotate amount, by round and step within group of four
  function automatic logic [4:0] md5_rot(input logic [5:0] idx);
    logic [4:0] r;
    case ({idx[5:4], idx[1:0]})
      4'd0:  r = 5'd7;   4'd1:  r = 5'd12;  4'd2:  r = 5'd17;  4'd3:  r = 5'd22;
      4'd4:  r = 5'd5;   4'd5:  r = 5'd9;   4'd6:  r = 5'd14;  4'd7:  r = 5'd20;
      4'd8:  r = 5'd4;   4'd9:  r = 5'd11;  4'd10: r = 5'd16;  4'd11: r = 5'd23;
      4'd12: r = 5'd6;   4'd13: r = 5'd10;  4'd14: r = 5'd15;  4'd15: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // message word used by a step
  function automatic logic [3:0] md5_msg_index(input logic [5:0] idx);
    logic [3:0] s;
    logic [3:0] g;
    s = idx[3:0];
    case (idx[5:4])
      2'd0:    g = s;
      2'd1:    g = (s << 2) + s + 4'd1;
      2'd2:    g = (s << 1) + s + 4'd5;
      2'd3:    g = (s << 3) - s;
      default: g = s;
    endcase
    return g;
  endfunction

endpackage

// ===== hdl/md5_ram.sv =====
// generic single write, single read ram with registered read data
module md5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/md5_core.sv =====
// md5 compression datapath: working registers, step logic and chaining value
module md5_core
  import md5_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  md5_ctrl_t        ctrl_i,
  input  logic [5:0]       step_idx_i,
  input  logic [31:0]      msg_i,
  output logic [3:0][31:0] chain_sum_o
);

  logic [31:0] chain_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] func;
  logic [31:0] sum;
  logic [63:0] sum_dbl;
  logic [31:0] new_b;

  // round function
  always_comb begin
    case (step_idx_i[5:4])
      2'd0:    func = (b_q & c_q) | (~b_q & d_q);
      2'd1:    func = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    func = b_q ^ c_q ^ d_q;
      2'd3:    func = c_q ^ (b_q | ~d_q);
      default: func = 32'h0;
    endcase
  end

  // one step: add, rotate, add
  assign sum     = a_q + func + md5_const(step_idx_i) + msg_i;
  assign sum_dbl = {sum, sum} << md5_rot(step_idx_i);
  assign new_b   = b_q + sum_dbl[63:32];

  // working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (ctrl_i.step) begin
      a_q <= d_q;
      b_q <= new_b;
      c_q <= b_q;
      d_q <= c_q;
    end
  end

  // chaining value plus block result
  assign chain_sum_o[0] = chain_q[0] + a_q;
  assign chain_sum_o[1] = chain_q[1] + b_q;
  assign chain_sum_o[2] = chain_q[2] + c_q;
  assign chain_sum_o[3] = chain_q[3] + d_q;

  // chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= MD5_IV_A;
      chain_q[1] <= MD5_IV_B;
      chain_q[2] <= MD5_IV_C;
      chain_q[3] <= MD5_IV_D;
    end else if (ctrl_i.fold) begin
      if (ctrl_i.restart) begin
        chain_q[0] <= MD5_IV_A;
        chain_q[1] <= MD5_IV_B;
        chain_q[2] <= MD5_IV_C;
        chain_q[3] <= MD5_IV_D;
      end else begin
        chain_q[0] <= chain_sum_o[0];
        chain_q[1] <= chain_sum_o[1];
        chain_q[2] <= chain_sum_o[2];
        chain_q[3] <= chain_sum_o[3];
      end
    end
  end

endmodule

// ===== hdl/md5_digest_engine.sv =====
// top level of the md5 digest engine: word intake, padding, sequencing, output
//
// Input channel: in_valid_i / in_stall_o carries one 32-bit message word per
// transfer, first byte in bits 7..0, with valid_bytes_i and last_word_i.
// Words other than the last always count as four bytes. On the last word
// valid_bytes_i gives 0..4 bytes (5..7 count as 4).
// Output channel: out_valid_o / out_stall_i carries the four digest words,
// one transfer per message.
// Each word is written into a 16-entry block buffer ram. Every 16th word
// starts a compression (a read-ahead step, 64 steps at one step per cycle,
// one fold into the chaining value), during which in_stall_o is high.
// After the last word the padding words are written one per cycle (up to
// 18 over two blocks), followed by one or two compressions; the digest
// then sits in an output register while new words are already taken in.
// If the output register is still held by a stalled receiver when the next
// digest is done, the engine waits with in_stall_o high until it drains.
// Reset returns the chaining value to its initial value and clears the
// word position and byte count; the buffer contents are not cleared.
module md5_digest_engine
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word0_o,
  output logic [31:0] digest_word1_o,
  output logic [31:0] digest_word2_o,
  output logic [31:0] digest_word3_o
);

  localparam int unsigned PosW = $clog2(MD5_BLOCK_WORDS);
  localparam int unsigned StepW = $clog2(MD5_STEPS);
  localparam logic [PosW-1:0] PosLenLo = PosW'(MD5_BLOCK_WORDS - 2);
  localparam logic [PosW-1:0] PosLast  = PosW'(MD5_BLOCK_WORDS - 1);
  localparam logic [StepW-1:0] StepLast = StepW'(MD5_STEPS - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_COMP = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [StepW-1:0] step_q, step_d;
  logic [60:0]      count_q, count_d;
  logic             tail_q, tail_d;
  logic             marker_q, marker_d;
  logic             len_hi_q, len_hi_d;
  logic             final_q, final_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic [31:0]      digest_q [4];

  logic             in_xfer;
  logic             out_free;
  logic [2:0]       nbytes;
  logic [31:0]      tail_word;

  logic             ram_we;
  logic [PosW-1:0]  ram_raddr;
  logic [31:0]      ram_wdata;
  logic [31:0]      ram_rdata;

  md5_ctrl_t        ctrl;
  logic [3:0][31:0] chain_sum;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // byte count of this word
  always_comb begin
    if (!last_word_i) begin
      nbytes = 3'd4;
    end else if (valid_bytes_i > 3'd4) begin
      nbytes = 3'd4;
    end else begin
      nbytes = valid_bytes_i;
    end
  end

  // last word with its unused bytes masked and, below four bytes, the end marker appended
  always_comb begin
    case (nbytes)
      3'd0:    tail_word = 32'h0000_0080;
      3'd1:    tail_word = {16'h0, 8'h80, data_word_i[7:0]};
      3'd2:    tail_word = {8'h0, 8'h80, data_word_i[15:0]};
      3'd3:    tail_word = {8'h80, data_word_i[23:0]};
      default: tail_word = data_word_i;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    step_d      = step_q;
    count_d     = count_q;
    tail_d      = tail_q;
    marker_d    = marker_q;
    len_hi_d    = len_hi_q;
    final_d     = final_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = data_word_i;
    ram_raddr   = md5_msg_index(step_q + StepW'(1));
    ctrl        = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          ram_we    = 1'b1;
          ram_wdata = last_word_i ? tail_word : data_word_i;
          pos_d     = pos_q + PosW'(1);
          count_d   = count_q + 61'(nbytes);
          if (last_word_i) begin
            tail_d   = 1'b1;
            marker_d = (nbytes == 3'd4);
          end
          if (pos_q == PosLast) begin
            state_d = ST_PREP;
          end else if (last_word_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ram_we   = 1'b1;
        pos_d    = pos_q + PosW'(1);
        marker_d = 1'b0;
        if (marker_q) begin
          ram_wdata = 32'h0000_0080;
        end else if (len_hi_q) begin
          ram_wdata = count_q[60:29];
          len_hi_d  = 1'b0;
          final_d   = 1'b1;
        end else if (pos_q == PosLenLo) begin
          ram_wdata = {count_q[28:0], 3'b000};
          len_hi_d  = 1'b1;
        end else begin
          ram_wdata = 32'h0;
        end
        if (pos_q == PosLast) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        ctrl.init = 1'b1;
        ram_raddr = md5_msg_index('0);
        step_d    = '0;
        state_d   = ST_COMP;
      end
      ST_COMP: begin
        ctrl.step = 1'b1;
        step_d    = step_q + StepW'(1);
        if (step_q == StepLast) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!final_q) begin
          ctrl.fold = 1'b1;
          state_d   = tail_q ? ST_PAD : ST_IDLE;
        end else if (out_free) begin
          ctrl.fold    = 1'b1;
          ctrl.restart = 1'b1;
          out_load     = 1'b1;
          out_valid_d  = 1'b1;
          tail_d       = 1'b0;
          final_d      = 1'b0;
          count_d      = '0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      step_q      <= '0;
      count_q     <= '0;
      tail_q      <= 1'b0;
      marker_q    <= 1'b0;
      len_hi_q    <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      step_q      <= step_d;
      count_q     <= count_d;
      tail_q      <= tail_d;
      marker_q    <= marker_d;
      len_hi_q    <= len_hi_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  // digest output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      digest_q[0] <= chain_sum[0];
      digest_q[1] <= chain_sum[1];
      digest_q[2] <= chain_sum[2];
      digest_q[3] <= chain_sum[3];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digest_word0_o = digest_q[0];
  assign digest_word1_o = digest_q[1];
  assign digest_word2_o = digest_q[2];
  assign digest_word3_o = digest_q[3];

  // block buffer
  md5_ram #(
    .WIDTH (MD5_WORD_W),
    .DEPTH (MD5_BLOCK_WORDS)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // compression datapath
  md5_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .step_idx_i  (step_q),
    .msg_i       (ram_rdata),
    .chain_sum_o (chain_sum)
  );

endmodule

// ===== hdl/md5_checker.sv =====
// port-level checks for the md5 digest engine, bound to the top level
module md5_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_word_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word0_o,
  input logic [31:0] digest_word3_o
);

  // a stalled digest holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word0_o)
      && $stable(digest_word3_o))
  else $error("stalled digest changed");

  // the last word always starts padding or a compression, so the input stalls next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_word_i |=> in_stall_o)
  else $error("input not stalled after last word");

  // a new digest is only produced at the end of a busy phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
  else $error("digest appeared while idle");

  // a word that is not last never produces a digest right away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !last_word_i |=> !$rose(out_valid_o))
  else $error("digest after non-last word");

endmodule

bind md5_digest_engine md5_checker u_md5_checker (.*);

// ===== tb/tb.sv =====
// testbench for md5_digest_engine: directed and random messages against an md5 predictor
module tb
  import md5_pkg::*;
();

  typedef logic [0:3][31:0] digest_t;

  // one directed transfer, with an optional hand-typed digest
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
    logic        known;
    digest_t     digest;
  } stim_row_t;

  localparam int NUM_DIRECTED = 17;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 300;

  // well known digests, words little-endian
  localparam digest_t DIG_EMPTY = {32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};
  localparam digest_t DIG_A     = {32'hb975c10c, 32'ha8b6f1c0, 32'he299c331, 32'h61267769};
  localparam digest_t DIG_ABC   = {32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128};
  localparam digest_t DIG_MSGD  = {32'h7d696bf9, 32'h8d93b77c, 32'h312f5a52, 32'hd061f1aa};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [31:0] data_word_i   = '0;
  logic [2:0]  valid_bytes_i = '0;
  logic        last_word_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [31:0] digest_word0_o;
  logic [31:0] digest_word1_o;
  logic [31:0] digest_word2_o;
  logic [31:0] digest_word3_o;

  // hand-typed digest that rides along with the current transfer
  logic        typed_known  = 1'b0;
  digest_t     typed_digest = '0;

  digest_t     digest_queue[$];
  int          fault_count    = 0;
  int          words_accepted = 0;
  int          digests_seen   = 0;
  int          cycle_count    = 0;

  // predictor state
  logic [31:0] hash_state [0:3];
  logic [31:0] block_words [0:15];
  logic [3:0]  block_fill;
  logic [60:0] msg_len_bytes;

  logic [31:0] step_k [0:63] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  int rot_s [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // directed messages: empty, masked tails, ignored byte counts, saturated counts
  stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    {32'h00000000, 3'd0, 1'b1, 1'b1, DIG_EMPTY},
    {32'hffffffff, 3'd0, 1'b1, 1'b1, DIG_EMPTY},
    {32'hffffff61, 3'd1, 1'b1, 1'b1, DIG_A},
    {32'h7f636261, 3'd3, 1'b1, 1'b1, DIG_ABC},
    {32'h7373656d, 3'd0, 1'b0, 1'b0, digest_t'(0)},
    {32'h20656761, 3'd7, 1'b0, 1'b0, digest_t'(0)},
    {32'h65676964, 3'd4, 1'b0, 1'b0, digest_t'(0)},
    {32'hffff7473, 3'd2, 1'b1, 1'b1, DIG_MSGD},
    {32'hffffffff, 3'd4, 1'b1, 1'b0, digest_t'(0)},
    {32'h00000000, 3'd5, 1'b1, 1'b0, digest_t'(0)},
    {32'h80000001, 3'd6, 1'b1, 1'b0, digest_t'(0)},
    {32'ha5a5a5a5, 3'd7, 1'b1, 1'b0, digest_t'(0)},
    {32'hffffffff, 3'd3, 1'b0, 1'b0, digest_t'(0)},
    {32'h12345678, 3'd1, 1'b0, 1'b0, digest_t'(0)},
    {32'h9abcdef0, 3'd0, 1'b1, 1'b0, digest_t'(0)},
    {32'h00000000, 3'd6, 1'b0, 1'b0, digest_t'(0)},
    {32'hffffffff, 3'd2, 1'b1, 1'b0, digest_t'(0)}
  };

  md5_digest_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_word_i    (data_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .last_word_i    (last_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digest_word0_o (digest_word0_o),
    .digest_word1_o (digest_word1_o),
    .digest_word2_o (digest_word2_o),
    .digest_word3_o (digest_word3_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void md5_clear_state();
    hash_state[0] = MD5_IV_A;
    hash_state[1] = MD5_IV_B;
    hash_state[2] = MD5_IV_C;
    hash_state[3] = MD5_IV_D;
    block_fill    = '0;
    msg_len_bytes = '0;
  endfunction

  // 64-step compression of the buffered block into the chaining value
  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, sum, b_next;
    int          g;
    int          rnd;
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    for (int i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      sum    = a + f + step_k[i] + block_words[g];
      b_next = b + rotl32(sum, rot_s[rnd * 4 + i % 4]);
      a = d;
      d = c;
      c = b;
      b = b_next;
    end
    hash_state[0] = hash_state[0] + a;
    hash_state[1] = hash_state[1] + b;
    hash_state[2] = hash_state[2] + c;
    hash_state[3] = hash_state[3] + d;
  endfunction

  function automatic void md5_push_word(input logic [31:0] w);
    block_words[block_fill] = w;
    block_fill = block_fill + 4'd1;
    if (block_fill == 4'd0) md5_compress();
  endfunction

  // absorb one accepted word; returns 1 with the digest on the last word
  function automatic bit md5_absorb_word(input logic [31:0] data, input logic [2:0] nbytes,
                                         input logic last, output digest_t dig);
    int          n;
    logic [31:0] mask;
    logic [63:0] bit_len;
    dig = '0;
    if (!last) begin
      md5_push_word(data);
      msg_len_bytes = msg_len_bytes + 61'd4;
      return 1'b0;
    end
    n = (nbytes > 3'd4) ? 4 : int'(nbytes);
    msg_len_bytes = msg_len_bytes + 61'(n);
    if (n == 4) begin
      md5_push_word(data);
      md5_push_word(32'h80);
    end else begin
      mask = (32'h1 << (8 * n)) - 32'h1;
      md5_push_word((data & mask) | (32'h80 << (8 * n)));
    end
    while (block_fill != 4'd14) md5_push_word(32'h0);
    bit_len = {msg_len_bytes, 3'b000};
    md5_push_word(bit_len[31:0]);
    md5_push_word(bit_len[63:32]);
    dig = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
    md5_clear_state();
    return 1'b1;
  endfunction

  // sender idles at random, except for a calm stretch of items
  function automatic bit sender_idles();
    if (words_accepted >= 500 && words_accepted < 850) return 1'b0;
    return $urandom_range(0, 99) < 24;
  endfunction

  // drive one word and hold it until the transfer happens
  task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                           input logic last, input logic known, input digest_t dig);
    while (sender_idles()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_word_i   <= data;
    valid_bytes_i <= nbytes;
    last_word_i   <= last;
    typed_known   <= known;
    typed_digest  <= dig;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // input transfers feed the predictor
  always @(posedge clk_i) begin
    digest_t dig;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      words_accepted <= words_accepted + 1;
      if (md5_absorb_word(data_word_i, valid_bytes_i, last_word_i, dig)) begin
        digest_queue.push_back(typed_known ? typed_digest : dig);
      end
    end
  end

  // output transfers checked against the oldest expected digest
  always @(posedge clk_i) begin
    digest_t want;
    digest_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      digests_seen <= digests_seen + 1;
      got = {digest_word0_o, digest_word1_o, digest_word2_o, digest_word3_o};
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest %h %h %h %h", $time,
                 got[0], got[1], got[2], got[3]);
        fault_count++;
      end else begin
        want = digest_queue.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got[k] !== want[k]) begin
            $display("%0t: digest_word%0d mismatch, expected %h, actual %h",
                     $time, k, want[k], got[k]);
            fault_count++;
          end
        end
      end
    end
  end

  // receiver stalls at random, except for a calm stretch of digests
  always @(negedge clk_i) begin
    if (!rst_ni || (digests_seen >= 15 && digests_seen < 30)) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 24);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d digests outstanding", $time, digest_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int n;
    int rand_items;
    rand_items = 0;
    md5_clear_state();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_word(directed_rows[r].data, directed_rows[r].nbytes, directed_rows[r].last,
                directed_rows[r].known, directed_rows[r].digest);
    end

    // random messages, lengths biased toward padding boundaries
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n = $urandom_range(0, 20);
        6, 7, 8:          n = 16 * $urandom_range(0, 2) + $urandom_range(11, 16);
        default:          n = $urandom_range(30, 70);
      endcase
      for (int w = 0; w < n; w++) begin
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
        rand_items++;
      end
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
      rand_items++;
    end
    in_valid_i <= 1'b0;

    // drain
    while (digest_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
